/* hdl/bcdss_pkg.sv */
// bcdss_pkg: shared types and constants for the bcd counter with display scan
// no dependencies
`default_nettype none

package bcdss_pkg;

  localparam int unsigned NumDigits = 4;
  localparam int unsigned IdxWidth  = 2;
  localparam int unsigned DigWidth  = 4;
  localparam int unsigned SegWidth  = 8;
  localparam int unsigned HoldWidth = 8;
  localparam int unsigned CntWidth  = 14;

  localparam logic [HoldWidth-1:0] ResetHold = 8'd5;
  localparam logic [DigWidth-1:0]  DigitMax  = 4'd9;
  localparam logic [SegWidth-1:0]  SegBlank  = 8'hFF;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_SET  = 2'd1,
    ACT_INC  = 2'd2,
    ACT_DEC  = 2'd3
  } action_t;

  typedef logic [DigWidth-1:0] digit_t;

  // active-low seven-segment pattern
  function automatic logic [SegWidth-1:0] seg_decode(input digit_t d);
    logic [SegWidth-1:0] s;
    case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* hdl/bcd_up_down_counter_seven_segment_scan_top.sv */
// four-digit bcd up/down counter with multiplexed seven-segment scan output
// depends on bcdss_pkg
// each accepted request's result is written to the output register
// throughput: one request per cycle; input is taken while a result waits if
//   the output register is being drained in the same cycle
// reset (synchronous, active high): digits, scan position and hold count zero,
//   hold setting 5, no result pending
`default_nettype none

module bcd_up_down_counter_seven_segment_scan_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // action[1:0], digit_index[3:2], digit_value[7:4]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // segments[7:0], digit_enables[11:8],
                                      // shown_digit[13:12], count_value[27:14], zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [bcdss_pkg::HoldWidth-1:0] cfg_data
);
  import bcdss_pkg::*;

  logic [HoldWidth-1:0] scan_hold_ticks;
  digit_t               digits [NumDigits];
  logic [IdxWidth-1:0]  scan_position;
  logic [HoldWidth-1:0] hold_counter;

  digit_t               digits_next [NumDigits];
  logic [IdxWidth-1:0]  scan_position_next;
  logic [HoldWidth-1:0] hold_counter_next;

  action_t              action;
  logic [IdxWidth-1:0]  digit_index;
  digit_t               digit_value;
  logic                 accept;

  logic [HoldWidth-1:0] hold_eff;
  logic [HoldWidth:0]   hold_inc;
  logic                 carry;
  logic                 borrow;
  digit_t               shown;
  logic [CntWidth-1:0]  count_next;

  assign action      = action_t'(s_tdata[1:0]);
  assign digit_index = s_tdata[3:2];
  assign digit_value = s_tdata[7:4];

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign hold_eff = (scan_hold_ticks == '0) ? HoldWidth'(1) : scan_hold_ticks;
  assign hold_inc = {1'b0, hold_counter} + (HoldWidth+1)'(1);

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      digits_next[i] = digits[i];
    end
    scan_position_next = scan_position;
    hold_counter_next  = hold_counter;
    carry              = 1'b0;
    borrow             = 1'b1;
    case (action)
      ACT_TICK: begin
        if (hold_inc >= {1'b0, hold_eff}) begin
          hold_counter_next  = '0;
          scan_position_next = scan_position + IdxWidth'(1);
        end else begin
          hold_counter_next = hold_inc[HoldWidth-1:0];
        end
      end
      ACT_SET: begin
        if (digit_value <= DigitMax) begin
          digits_next[digit_index] = digit_value;
        end
      end
      ACT_INC: begin
        for (int i = NumDigits - 1; i >= 0; i--) begin
          if (carry || (IdxWidth'(i) == digit_index)) begin
            if (digits[i] < DigitMax) begin
              digits_next[i] = digits[i] + DigWidth'(1);
              carry          = 1'b0;
            end else begin
              digits_next[i] = '0;
              carry          = 1'b1;
            end
          end
        end
        // carry out of the top digit clears the count
        if (carry) begin
          for (int i = 0; i < NumDigits; i++) begin
            digits_next[i] = '0;
          end
        end
      end
      ACT_DEC: begin
        // borrow chain; all zero wraps to 9999
        for (int i = NumDigits - 1; i >= 0; i--) begin
          if (borrow) begin
            if (digits[i] == '0) begin
              digits_next[i] = DigitMax;
            end else begin
              digits_next[i] = digits[i] - DigWidth'(1);
              borrow         = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign shown      = digits_next[scan_position_next];
  assign count_next = CntWidth'(digits_next[0]) * CntWidth'(1000)
                    + CntWidth'(digits_next[1]) * CntWidth'(100)
                    + CntWidth'(digits_next[2]) * CntWidth'(10)
                    + CntWidth'(digits_next[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_hold_ticks <= ResetHold;
      for (int i = 0; i < NumDigits; i++) begin
        digits[i] <= '0;
      end
      scan_position <= '0;
      hold_counter  <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        scan_hold_ticks <= cfg_data;
      end
      if (accept) begin
        for (int i = 0; i < NumDigits; i++) begin
          digits[i] <= digits_next[i];
        end
        scan_position <= scan_position_next;
        hold_counter  <= hold_counter_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {4'b0000, count_next, scan_position_next,
                  ~(NumDigits'(1) << scan_position_next), seg_decode(shown)};
    end
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// tb_top: self-checking bench for the four-digit bcd counter with seven-segment scan
// a directed table then random requests; results checked against predictor or table
// depends on bcdss_pkg and bcd_up_down_counter_seven_segment_scan_top
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bcdss_pkg::*;

  localparam int unsigned MaxCount  = 9999;
  localparam int unsigned TopWeight = 1000;
  localparam int unsigned Phases    = 8;
  localparam int unsigned PhaseLen  = 212;
  localparam logic [79:0] SegLut = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
                                    8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};
  localparam logic [63:0] HoldPlan = {8'd1, 8'd4, 8'd0, 8'd0, 8'd2,
                                      8'd3, 8'd255, 8'd1};

  typedef struct packed {
    logic [SegWidth-1:0] seg;
    logic [3:0]          en;
    logic [1:0]          pos;
    logic [CntWidth-1:0] cnt;
  } disp_t;

  typedef struct {
    logic                 is_hold;
    logic [HoldWidth-1:0] hold;
    action_t              act;
    logic [1:0]           idx;
    logic [3:0]           val;
    logic                 typed;
    disp_t                want;
  } dir_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [HoldWidth-1:0] cfg_data = '0;

  digit_t               cur_digits [NumDigits];
  logic [1:0]           scan_pos = '0;
  logic [HoldWidth-1:0] hold_cnt = '0;
  logic [HoldWidth-1:0] hold_set = ResetHold;

  disp_t                pending_displays [$];
  dir_row_t             dir_tab [$];
  int unsigned          mismatch_cnt = 0;
  int unsigned          idle_pct = 20;
  int unsigned          stall_left = 0;

  bcd_up_down_counter_seven_segment_scan_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r >= idle_pct) return 0;
    if (r < 3) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic int unsigned counter_value();
    int unsigned v;
    v = 0;
    for (int i = 0; i < NumDigits; i++) v = v * 10 + 32'(cur_digits[i]);
    return v;
  endfunction

  task automatic advance_counter(input action_t act, input logic [1:0] idx,
                                 input logic [3:0] val, output disp_t res);
    int unsigned lim;
    int unsigned total;
    int          p;
    logic        carry;
    case (act)
      ACT_TICK: begin
        lim = (hold_set == '0) ? 1 : 32'(hold_set);
        if (int'(hold_cnt) + 1 >= lim) begin
          hold_cnt = '0;
          scan_pos = scan_pos + 2'd1;
        end else begin
          hold_cnt = hold_cnt + 8'd1;
        end
      end
      ACT_SET: begin
        if (val <= DigitMax) cur_digits[idx] = val;
      end
      ACT_INC: begin
        p = int'(idx);
        carry = 1'b1;
        while (carry) begin
          if (cur_digits[p] < DigitMax) begin
            cur_digits[p] = cur_digits[p] + 4'd1;
            carry = 1'b0;
          end else begin
            cur_digits[p] = '0;
            if (p == 0) begin
              for (int i = 0; i < NumDigits; i++) cur_digits[i] = '0;
              carry = 1'b0;
            end else begin
              p--;
            end
          end
        end
      end
      default: begin
        total = counter_value();
        total = (total == 0) ? MaxCount : total - 1;
        cur_digits[0] = digit_t'(total / TopWeight);
        cur_digits[1] = digit_t'((total / 100) % 10);
        cur_digits[2] = digit_t'((total / 10) % 10);
        cur_digits[3] = digit_t'(total % 10);
      end
    endcase
    res.seg = SegLut[8 * int'(cur_digits[scan_pos]) +: 8];
    res.en  = ~(4'b0001 << scan_pos);
    res.pos = scan_pos;
    res.cnt = CntWidth'(counter_value());
  endtask

  task automatic send_req(input action_t act, input logic [1:0] idx,
                          input logic [3:0] val, input logic typed, input disp_t want);
    int unsigned gap;
    disp_t       res;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {val, idx, act};
    do @(posedge clk); while (!s_tready);
    advance_counter(act, idx, val, res);
    pending_displays.push_back(typed ? want : res);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_hold(input logic [HoldWidth-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    hold_set = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input action_t act, input logic [1:0] idx, input logic [3:0] val);
    dir_row_t row;
    row = '{1'b0, '0, act, idx, val, 1'b0, '0};
    dir_tab.push_back(row);
  endtask

  task automatic add_typed(input action_t act, input logic [1:0] idx, input logic [3:0] val,
                           input logic [7:0] seg, input logic [13:0] cnt);
    dir_row_t row;
    row = '{1'b0, '0, act, idx, val, 1'b1, '{seg, 4'b1110, 2'd0, cnt}};
    dir_tab.push_back(row);
  endtask

  task automatic add_hold(input logic [HoldWidth-1:0] v);
    dir_row_t row;
    row = '{1'b1, v, ACT_TICK, '0, '0, 1'b0, '0};
    dir_tab.push_back(row);
  endtask

  always @(posedge clk) begin
    disp_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_displays.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
      end else begin
        want = pending_displays.pop_front();
        if (m_tdata[7:0] !== want.seg) begin
          mismatch_cnt++;
          $display("%0t: segments expected %h actual %h", $time, want.seg, m_tdata[7:0]);
        end
        if (m_tdata[11:8] !== want.en) begin
          mismatch_cnt++;
          $display("%0t: digit_enables expected %h actual %h", $time, want.en, m_tdata[11:8]);
        end
        if (m_tdata[13:12] !== want.pos) begin
          mismatch_cnt++;
          $display("%0t: shown_digit expected %0d actual %0d", $time, want.pos,
                   m_tdata[13:12]);
        end
        if (m_tdata[27:14] !== want.cnt) begin
          mismatch_cnt++;
          $display("%0t: count_value expected %0d actual %0d", $time, want.cnt,
                   m_tdata[27:14]);
        end
      end
    end
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready   <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  initial begin
    dir_row_t    row;
    action_t     act;
    logic [1:0]  idx;
    logic [3:0]  val;
    int unsigned r;
    for (int i = 0; i < NumDigits; i++) cur_digits[i] = '0;

    add_typed(ACT_TICK, 2'd0, 4'd0,  8'hC0, 14'd0);
    add_typed(ACT_SET,  2'd0, 4'd9,  8'h90, 14'd9000);
    add_typed(ACT_SET,  2'd3, 4'd15, 8'h90, 14'd9000);
    add_typed(ACT_SET,  2'd1, 4'd10, 8'h90, 14'd9000);
    add_typed(ACT_SET,  2'd3, 4'd9,  8'h90, 14'd9009);
    add_row(ACT_SET, 2'd2, 4'd9);
    add_row(ACT_SET, 2'd1, 4'd9);
    add_typed(ACT_INC,  2'd3, 4'd0,  8'hC0, 14'd0);
    add_typed(ACT_DEC,  2'd0, 4'd0,  8'h90, 14'd9999);
    add_row(ACT_DEC, 2'd2, 4'd15);
    add_typed(ACT_INC,  2'd0, 4'd0,  8'hC0, 14'd0);
    add_row(ACT_SET, 2'd2, 4'd9);
    add_row(ACT_INC, 2'd2, 4'd0);
    add_row(ACT_SET, 2'd0, 4'd1);
    add_row(ACT_DEC, 2'd1, 4'd5);
    repeat (4) add_row(ACT_TICK, 2'd3, 4'd15);
    add_hold(8'd255);
    repeat (3) add_row(ACT_TICK, 2'd1, 4'd6);
    add_hold(8'd2);
    add_row(ACT_TICK, 2'd0, 4'd0);
    add_hold(8'd0);
    add_row(ACT_TICK, 2'd2, 4'd10);
    add_row(ACT_TICK, 2'd1, 4'd5);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.is_hold) begin
        settle();
        write_hold(row.hold);
      end else begin
        send_req(row.act, row.idx, row.val, row.typed, row.want);
      end
    end

    for (int ph = 0; ph < Phases; ph++) begin
      settle();
      if (ph == 4) write_hold(HoldWidth'($urandom_range(0, 255)));
      else write_hold(HoldPlan[8 * ph +: 8]);
      idle_pct = (ph % 3 == 2) ? 0 : ((ph % 3 == 1) ? 50 : 20);
      for (int n = 0; n < PhaseLen; n++) begin
        r = $urandom_range(0, 99);
        act = (r < 40) ? ACT_TICK : (r < 65) ? ACT_SET : (r < 85) ? ACT_INC : ACT_DEC;
        idx = 2'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        val = (r < 20) ? 4'd9 : (r < 30) ? 4'd0 : 4'($urandom_range(0, 15));
        send_req(act, idx, val, 1'b0, '0);
      end
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
